// ----- rtl/tst_pkg.sv -----
// shared types and constants of the topic subscription table
package tst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TOPIC_BITS_DEF = 32;
    localparam int TOPIC_IN_W     = 32;
    localparam int SUB_W          = 16;
    localparam int SEND_W         = 32;

    typedef enum logic [2:0] {
        OP_PUBLISH   = 3'd0,
        OP_UNPUBLISH = 3'd1,
        OP_SEND      = 3'd2,
        OP_SUBSCRIBE = 3'd3,
        OP_LOCAL_SUB = 3'd4,
        OP_UNSUB     = 3'd5,
        OP_QUERY     = 3'd6,
        OP_LIST      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MOD,
        S_LIST
    } t_state;

    typedef struct packed {
        logic              is_local;
        logic [SUB_W-1:0]  subs;
        logic [SEND_W-1:0] sends;
    } t_cnt;

    typedef struct packed {
        logic set;
        logic clr;
    } t_cam_wr;

    typedef struct packed {
        logic hit;
        logic has_free;
    } t_cam_res;

endpackage

// ----- rtl/topic_subscription_table.sv -----
// top level of the topic subscription table: control sequencer and result register
//
// Table of SLOT_COUNT topic slots. Topic ids and valid marks sit in registers and are
// matched in parallel; subscriber count, send count and local flag of each slot sit in
// a synchronous memory with a registered read. An item takes a lookup cycle that
// matches the topic and reads the slot's counters, then an update cycle that writes
// the counters back and loads the result register; the update waits while a result
// is held. The next item is taken in the update cycle while results are drained. A
// list item gives SLOT_COUNT results at one per cycle while no result is held, then
// the block is free again. No clearing pass is needed after reset.
module topic_subscription_table #(
    parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF,
    parameter int TOPIC_BITS = tst_pkg::TOPIC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_topic_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_is_local,
    output logic [15:0] o_subscriber_count,
    output logic [31:0] o_sent_count,
    output logic [31:0] o_listed_topic,
    output logic        o_last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $bits(tst_pkg::t_cnt);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    tst_pkg::t_state  r_state, n_state;
    tst_pkg::t_op     r_op;
    logic [TOPIC_BITS-1:0] r_key;
    logic             r_hit, r_has_free;
    logic [IDX_W-1:0] r_idx, r_cnt;

    logic             r_out_valid;
    tst_pkg::t_status r_out_status;
    logic             r_out_local;
    logic [15:0]      r_out_subs;
    logic [31:0]      r_out_sends;
    logic [31:0]      r_out_topic;
    logic             r_out_last;

    logic [63:0]           w_topic_ext;
    logic [TOPIC_BITS-1:0] w_key;
    logic                  w_in_acc, w_out_free;
    logic                  w_rd_en, w_mod, w_list_step;

    tst_pkg::t_cam_res     w_cam_res;
    tst_pkg::t_cam_wr      w_cam_wr;
    logic [IDX_W-1:0]      w_hit_idx, w_free_idx;
    logic                  w_list_valid;
    logic [TOPIC_BITS-1:0] w_list_topic;
    logic [63:0]           w_list_ext;

    tst_pkg::t_cnt    w_rd, w_wdata;
    logic [CNT_W-1:0] w_rdata_raw;
    logic             w_we;

    tst_pkg::t_status w_res_status;
    tst_pkg::t_cnt    w_res;

    assign w_topic_ext = 64'(i_topic_id);
    assign w_key       = w_topic_ext[TOPIC_BITS-1:0];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == tst_pkg::S_IDLE) ||
                           ((r_state == tst_pkg::S_MOD) && w_out_free));
    assign w_in_acc    = i_in_valid && !o_in_stall;

    tst_cam #(
        .SLOT_COUNT (SLOT_COUNT),
        .TOPIC_BITS (TOPIC_BITS),
        .IDX_W      (IDX_W)
    ) u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_wr         (w_cam_wr),
        .i_wr_idx     (r_idx),
        .i_list_idx   (r_cnt),
        .o_res        (w_cam_res),
        .o_hit_idx    (w_hit_idx),
        .o_free_idx   (w_free_idx),
        .o_list_valid (w_list_valid),
        .o_list_topic (w_list_topic)
    );

    tst_ram #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (CNT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_hit_idx),
        .o_rdata (w_rdata_raw)
    );

    assign w_rd       = tst_pkg::t_cnt'(w_rdata_raw);
    assign w_list_ext = 64'(w_list_topic);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_rd_en     = 1'b0;
        w_mod       = 1'b0;
        w_list_step = 1'b0;
        case (r_state)
            tst_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = tst_pkg::S_LOOK;
                end
            end
            tst_pkg::S_LOOK: begin
                if (r_op == tst_pkg::OP_LIST) begin
                    n_state = tst_pkg::S_LIST;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = tst_pkg::S_MOD;
                end
            end
            tst_pkg::S_MOD: begin
                if (w_out_free) begin
                    w_mod   = 1'b1;
                    n_state = w_in_acc ? tst_pkg::S_LOOK : tst_pkg::S_IDLE;
                end
            end
            tst_pkg::S_LIST: begin
                if (w_out_free) begin
                    w_list_step = 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        n_state = tst_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = tst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= tst_pkg::t_op'(i_opcode);
            r_key <= w_key;
        end
        if (w_rd_en) begin
            r_hit      <= w_cam_res.hit;
            r_has_free <= w_cam_res.has_free;
            r_idx      <= w_cam_res.hit ? w_hit_idx : w_free_idx;
        end
        if (r_state == tst_pkg::S_LOOK) begin
            r_cnt <= '0;
        end else if (w_list_step) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // update of the matched slot, or of the first free slot on publish
    always_comb begin
        w_res_status = tst_pkg::ST_DONE;
        w_res        = w_rd;
        w_we         = 1'b0;
        w_cam_wr     = '0;
        if (r_op == tst_pkg::OP_PUBLISH) begin
            if (r_hit) begin
                w_res_status = tst_pkg::ST_PRESENT;
            end else if (r_has_free) begin
                w_res      = '0;
                w_we       = w_mod;
                w_cam_wr.set = w_mod;
            end else begin
                w_res_status = tst_pkg::ST_FULL;
                w_res        = '0;
            end
        end else if (!r_hit) begin
            w_res_status = tst_pkg::ST_NOT_FOUND;
            w_res        = '0;
        end else begin
            case (r_op)
                tst_pkg::OP_UNPUBLISH: begin
                    w_res        = '0;
                    w_cam_wr.clr = w_mod;
                end
                tst_pkg::OP_SEND: begin
                    if (w_rd.sends != '1) begin
                        w_res.sends = w_rd.sends + 32'd1;
                    end
                    w_we = w_mod;
                end
                tst_pkg::OP_SUBSCRIBE, tst_pkg::OP_LOCAL_SUB: begin
                    if (w_rd.subs != '1) begin
                        w_res.subs = w_rd.subs + 16'd1;
                    end
                    if (r_op == tst_pkg::OP_LOCAL_SUB) begin
                        w_res.is_local = 1'b1;
                    end
                    w_we = w_mod;
                end
                tst_pkg::OP_UNSUB: begin
                    if (w_rd.subs != '0) begin
                        w_res.subs = w_rd.subs - 16'd1;
                    end
                    w_we = w_mod;
                end
                default: begin
                    w_res = w_rd;
                end
            endcase
        end
        w_wdata = w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_mod || w_list_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mod) begin
            r_out_status <= w_res_status;
            r_out_local  <= w_res.is_local;
            r_out_subs   <= w_res.subs;
            r_out_sends  <= w_res.sends;
            r_out_topic  <= '0;
            r_out_last   <= 1'b1;
        end else if (w_list_step) begin
            r_out_status <= tst_pkg::ST_DONE;
            r_out_local  <= 1'b0;
            r_out_subs   <= '0;
            r_out_sends  <= '0;
            r_out_topic  <= w_list_valid ? w_list_ext[31:0] : 32'd0;
            r_out_last   <= (r_cnt == LAST_IDX);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_is_local         = r_out_local;
    assign o_subscriber_count = r_out_subs;
    assign o_sent_count       = r_out_sends;
    assign o_listed_topic     = r_out_topic;
    assign o_last             = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mod || w_list_step) |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while held");

    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (r_state == tst_pkg::S_IDLE || r_state == tst_pkg::S_MOD))
        else $error("item taken while busy");

    a_list_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tst_pkg::S_LIST) |-> (r_op == tst_pkg::OP_LIST))
        else $error("list run without list item");

    a_write_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we || w_cam_wr.set || w_cam_wr.clr) |-> (r_state == tst_pkg::S_MOD))
        else $error("slot write outside update cycle");

    a_mod_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tst_pkg::S_MOD) |-> ($past(r_state) == tst_pkg::S_LOOK ||
                                         $past(r_state) == tst_pkg::S_MOD))
        else $error("update without lookup");

endmodule

// ----- rtl/tst_ram.sv -----
// single-port-write, single-port-read synchronous memory for the slot counters
module tst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tst_cam.sv -----
// slot valid bits and topic registers with parallel match and first-free search
module tst_cam #(
    parameter int SLOT_COUNT = tst_pkg::SLOT_COUNT_DEF,
    parameter int TOPIC_BITS = tst_pkg::TOPIC_BITS_DEF,
    parameter int IDX_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [TOPIC_BITS-1:0] i_key,
    input  tst_pkg::t_cam_wr      i_wr,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  logic [IDX_W-1:0]      i_list_idx,
    output tst_pkg::t_cam_res     o_res,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic                  o_list_valid,
    output logic [TOPIC_BITS-1:0] o_list_topic
);

    logic [SLOT_COUNT-1:0] r_valid;
    logic [TOPIC_BITS-1:0] r_topic [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr.set) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_wr.clr) begin
                r_valid[i_wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.set) begin
            r_topic[i_wr_idx] <= i_key;
        end
    end

    // lowest-numbered slot wins
    always_comb begin
        o_hit_idx  = '0;
        o_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_topic[i] == i_key);
            if (w_match[i]) begin
                o_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                o_free_idx = IDX_W'(i);
            end
        end
        o_res.hit      = |w_match;
        o_res.has_free = ~&r_valid;
    end

    assign o_list_valid = r_valid[i_list_idx];
    assign o_list_topic = r_topic[i_list_idx];

endmodule

// ----- tb/tb_topic_subscription_table.sv -----
// testbench of the topic subscription table: directed table then random transactions
`timescale 1ns / 1ps

module tb_topic_subscription_table;

    localparam int SLOT_N      = tst_pkg::SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_N    = 160;

    typedef struct packed {
        tst_pkg::t_op     op;
        logic [31:0]      topic;
        logic             typed;
        tst_pkg::t_status st;
    } t_item;

    typedef struct {
        tst_pkg::t_op     op;
        logic [31:0]      topic;
        logic [31:0]      step;
        int               reps;
        bit               typed;
        tst_pkg::t_status st;
    } t_row;

    typedef struct packed {
        tst_pkg::t_status status;
        logic             is_local;
        logic [15:0]      subs;
        logic [31:0]      sends;
        logic [31:0]      listed;
        logic             last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_topic_id = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_is_local;
    logic [15:0] o_subscriber_count;
    logic [31:0] o_sent_count;
    logic [31:0] o_listed_topic;
    logic        o_last;

    // table mirror
    logic        tbl_valid [SLOT_N];
    logic [31:0] tbl_topic [SLOT_N];
    logic [15:0] tbl_subs  [SLOT_N];
    logic [31:0] tbl_sends [SLOT_N];
    logic        tbl_local [SLOT_N];

    t_row        dir_rows [$];
    t_item       item_q [$];
    t_result     result_q [$];
    t_item       cur_item;

    int          err_cnt = 0;
    int          n_accepted = 0;
    int          n_cycles = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          stall_phase = 0;

    topic_subscription_table i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_topic_id         (i_topic_id),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_is_local         (o_is_local),
        .o_subscriber_count (o_subscriber_count),
        .o_sent_count       (o_sent_count),
        .o_listed_topic     (o_listed_topic),
        .o_last             (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int find_topic(input logic [31:0] t);
        int hit;
        hit = -1;
        for (int i = SLOT_N - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_topic[i] == t) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // updates the mirror and queues the expected results of one transaction
    task automatic apply_item(input t_item it);
        t_result r;
        t_result typed_r;
        int      s;
        int      f;
        r = '0;
        r.last = 1'b1;
        s = find_topic(it.topic);
        if (it.op == tst_pkg::OP_LIST) begin
            for (int i = 0; i < SLOT_N; i++) begin
                r.listed = tbl_valid[i] ? tbl_topic[i] : 32'd0;
                r.last = (i == SLOT_N - 1);
                result_q.push_back(r);
            end
        end else begin
            if (it.op == tst_pkg::OP_PUBLISH) begin
                if (s >= 0) begin
                    r.status = tst_pkg::ST_PRESENT;
                    r.is_local = tbl_local[s];
                    r.subs = tbl_subs[s];
                    r.sends = tbl_sends[s];
                end else begin
                    f = -1;
                    for (int i = SLOT_N - 1; i >= 0; i--) begin
                        if (!tbl_valid[i]) begin
                            f = i;
                        end
                    end
                    if (f < 0) begin
                        r.status = tst_pkg::ST_FULL;
                    end else begin
                        tbl_valid[f] = 1'b1;
                        tbl_topic[f] = it.topic;
                        tbl_subs[f] = '0;
                        tbl_sends[f] = '0;
                        tbl_local[f] = 1'b0;
                        r.status = tst_pkg::ST_DONE;
                    end
                end
            end else if (s < 0) begin
                r.status = tst_pkg::ST_NOT_FOUND;
            end else begin
                case (it.op)
                    tst_pkg::OP_UNPUBLISH: tbl_valid[s] = 1'b0;
                    tst_pkg::OP_SEND: begin
                        if (tbl_sends[s] != '1) tbl_sends[s] = tbl_sends[s] + 32'd1;
                    end
                    tst_pkg::OP_SUBSCRIBE: begin
                        if (tbl_subs[s] != '1) tbl_subs[s] = tbl_subs[s] + 16'd1;
                    end
                    tst_pkg::OP_LOCAL_SUB: begin
                        if (tbl_subs[s] != '1) tbl_subs[s] = tbl_subs[s] + 16'd1;
                        tbl_local[s] = 1'b1;
                    end
                    tst_pkg::OP_UNSUB: begin
                        if (tbl_subs[s] != '0) tbl_subs[s] = tbl_subs[s] - 16'd1;
                    end
                    default: ;
                endcase
                r.status = tst_pkg::ST_DONE;
                if (it.op != tst_pkg::OP_UNPUBLISH) begin
                    r.is_local = tbl_local[s];
                    r.subs = tbl_subs[s];
                    r.sends = tbl_sends[s];
                end
            end
            if (it.typed) begin
                typed_r = '0;
                typed_r.status = it.st;
                typed_r.last = 1'b1;
                result_q.push_back(typed_r);
            end else begin
                result_q.push_back(r);
            end
        end
    endtask

    function automatic void add_row(input tst_pkg::t_op op, input logic [31:0] topic,
                                    input logic [31:0] step, input int reps,
                                    input bit typed, input tst_pkg::t_status st);
        t_row row;
        row.op = op;
        row.topic = topic;
        row.step = step;
        row.reps = reps;
        row.typed = typed;
        row.st = st;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // sender: bursts with gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_item(cur_item);
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0 || item_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_in_valid <= 1'b0;
                    i_topic_id <= $urandom;
                end else begin
                    cur_item = item_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= cur_item.op;
                    i_topic_id <= cur_item.topic;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && n_accepted >= 40) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end else begin
                    mode_left--;
                end
                stall_phase++;
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (stall_phase % 3 == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $error("result with no transaction pending: status %0d listed %0h",
                       o_status, o_listed_topic);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("is_local", 64'(want.is_local), 64'(o_is_local));
                check_field("subscriber_count", 64'(want.subs), 64'(o_subscriber_count));
                check_field("sent_count", 64'(want.sends), 64'(o_sent_count));
                check_field("listed_topic", 64'(want.listed), 64'(o_listed_topic));
                check_field("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL topic_subscription_table");
            $finish;
        end
    end

    initial begin
        t_item       it;
        logic [31:0] topic_pool [24];
        int          pick;

        for (int i = 0; i < SLOT_N; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_topic[i] = '0;
            tbl_subs[i] = '0;
            tbl_sends[i] = '0;
            tbl_local[i] = 1'b0;
        end

        add_row(tst_pkg::OP_QUERY,     32'h0000_1234, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_LIST,      32'h0000_0000, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_PUBLISH,   32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_PUBLISH,   32'hFFFF_FFFF, 0, 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_PUBLISH,   32'hFFFF_FFFF, 0, 1, 1'b1, tst_pkg::ST_PRESENT);
        add_row(tst_pkg::OP_SEND,      32'hFFFF_FFFF, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_SUBSCRIBE, 32'h0000_0000, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_LOCAL_SUB, 32'hFFFF_FFFF, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_UNSUB,     32'h0000_0000, 0, 2, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_QUERY,     32'hFFFF_FFFF, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_QUERY,     32'h0000_0000, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_UNPUBLISH, 32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_UNPUBLISH, 32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_SEND,      32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_SUBSCRIBE, 32'h5A5A_5A5A, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_LOCAL_SUB, 32'hA5A5_A5A5, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_UNSUB,     32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        add_row(tst_pkg::OP_QUERY,     32'h0000_0000, 0, 1, 1'b1, tst_pkg::ST_NOT_FOUND);
        // fill the table
        add_row(tst_pkg::OP_PUBLISH,   32'h0000_0100, 1, SLOT_N - 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_PUBLISH,   32'hDEAD_BEEF, 0, 1, 1'b1, tst_pkg::ST_FULL);
        add_row(tst_pkg::OP_LIST,      32'hFFFF_FFFF, 0, 1, 1'b0, tst_pkg::ST_DONE);
        // repeated updates on one slot
        add_row(tst_pkg::OP_SUBSCRIBE, 32'h0000_0100, 0, 3, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_LOCAL_SUB, 32'h0000_0100, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_UNSUB,     32'h0000_0100, 0, 1, 1'b0, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_UNPUBLISH, 32'h0000_0105, 0, 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_PUBLISH,   32'hDEAD_BEEF, 0, 1, 1'b1, tst_pkg::ST_DONE);
        add_row(tst_pkg::OP_LIST,      32'h0000_0000, 0, 1, 1'b0, tst_pkg::ST_DONE);

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                it.op = dir_rows[r].op;
                it.topic = dir_rows[r].topic + dir_rows[r].step * k;
                it.typed = dir_rows[r].typed;
                it.st = dir_rows[r].st;
                item_q.push_back(it);
            end
        end

        for (int i = 0; i < 24; i++) begin
            topic_pool[i] = (i < 8) ? 32'h0000_0100 + i : $urandom;
        end
        topic_pool[8] = 32'h0000_0000;
        topic_pool[9] = 32'hFFFF_FFFF;
        topic_pool[10] = 32'hDEAD_BEEF;

        for (int n = 0; n < RANDOM_N; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      it.op = tst_pkg::OP_PUBLISH;
            else if (pick < 35) it.op = tst_pkg::OP_UNPUBLISH;
            else if (pick < 50) it.op = tst_pkg::OP_SEND;
            else if (pick < 62) it.op = tst_pkg::OP_SUBSCRIBE;
            else if (pick < 70) it.op = tst_pkg::OP_LOCAL_SUB;
            else if (pick < 82) it.op = tst_pkg::OP_UNSUB;
            else if (pick < 94) it.op = tst_pkg::OP_QUERY;
            else                it.op = tst_pkg::OP_LIST;
            it.topic = ($urandom_range(0, 99) < 85) ? topic_pool[$urandom_range(0, 23)]
                                                     : $urandom;
            it.typed = 1'b0;
            it.st = tst_pkg::ST_DONE;
            item_q.push_back(it);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || i_in_valid || result_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("PASS topic_subscription_table");
        end else begin
            $display("FAIL topic_subscription_table");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tst_pkg.sv
rtl/tst_ram.sv
rtl/tst_cam.sv
rtl/topic_subscription_table.sv
tb/tb_topic_subscription_table.sv
